FILE: rtl/sat_pkg.sv
// Shared types and codes for the sorted array table.
// Request, response and compare-result structs plus action and status codes.
// No dependencies.
package sat_pkg;

   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int ACTION_W   = 2;
   localparam int FIELD_W    = 32;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 9;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [FIELD_W-1:0] value;
      logic [POSITION_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [INDEX_W-1:0]        found_index;
      logic signed [FIELD_W-1:0] read_value;
      logic [COUNT_W-1:0]        entry_count;
      logic signed [FIELD_W-1:0] smallest;
      logic signed [FIELD_W-1:0] largest;
   } rsp_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

endpackage

FILE: rtl/sorted_array_table.sv
// Sorted array table; depends on sat_pkg, sat_ram and sat_cmp. Find runs a binary search,
// each probe a read and then a compare, and finishes on a hit or when the range runs out;
// read-at fetches and then captures the entry; insert searches (not when the table is
// empty), shifts the entries at and above the slot up one place and places the value.
// Refused and trivial requests go straight to the finish step. One item at a time; a
// stalled response holds the finish step. Synchronous reset clears state, count, shift flag, rsp valid.
module sorted_array_table
   import sat_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PROBE   = 3'd1;
   localparam logic [2:0] ST_COMPARE = 3'd2;
   localparam logic [2:0] ST_SHIFT   = 3'd3;
   localparam logic [2:0] ST_PLACE   = 3'd4;
   localparam logic [2:0] ST_FETCH   = 3'd5;
   localparam logic [2:0] ST_CAPTURE = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   // Low VALUE_WIDTH bits of the request, sign-extended from bit 31 only when that bit fits.
   function automatic logic [VALUE_WIDTH-1:0] widen(input logic [FIELD_W-1:0] raw);
      logic [VALUE_WIDTH+FIELD_W-1:0] tmp;
      tmp = {{VALUE_WIDTH{raw[FIELD_W-1]}}, raw};
      return tmp[VALUE_WIDTH-1:0];
   endfunction

   // Response fields carry the stored bits zero-extended or cut to the field width.
   function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] x);
      logic [VALUE_WIDTH+FIELD_W-1:0] tmp;
      tmp = {{FIELD_W{1'b0}}, x};
      return tmp[FIELD_W-1:0];
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [ACTION_W-1:0]    action_ff, action_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       mid_ff, mid_in;
   logic                   less_ff, less_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       wr_addr_ff, wr_addr_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] rdv_ff, rdv_in;
   logic [VALUE_WIDTH-1:0] first_ff, first_in;
   logic [VALUE_WIDTH-1:0] last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_rdata;
   cmp_type                cmp;

   logic [CNT_W:0]            mid_sum;
   logic [IDX_W-1:0]          probe_idx;
   logic [CNT_W-1:0]          ptr_m1;
   logic [CNT_W+POSITION_W-1:0] req_pos_wide;
   logic [CNT_W+POSITION_W-1:0] count_wide;
   logic [IDX_W+POSITION_W-1:0] req_pos_idx;
   logic [IDX_W+INDEX_W-1:0]    idx_wide;
   logic [CNT_W+COUNT_W-1:0]    cnt_wide;
   logic                        rsp_load;

   sat_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sat_cmp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .key    (value_ff),
      .entry  (ram_rdata),
      .result (cmp)
   );

   // The search keeps hi exclusive, so the probe is floor((lo + hi - 1) / 2).
   assign mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);
   assign probe_idx    = mid_sum[IDX_W:1];
   assign ptr_m1       = ptr_ff - CNT_W'(1);
   assign req_pos_wide = {{CNT_W{1'b0}}, req_data.position};
   assign count_wide   = {{POSITION_W{1'b0}}, count_ff};
   assign req_pos_idx  = {{IDX_W{1'b0}}, req_data.position};
   assign idx_wide     = {{INDEX_W{1'b0}}, idx_ff};
   assign cnt_wide     = {{COUNT_W{1'b0}}, count_ff};

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      less_in    = less_ff;
      slot_in    = slot_ff;
      ptr_in     = ptr_ff;
      pend_in    = pend_ff;
      wr_addr_in = wr_addr_ff;
      status_in  = status_ff;
      idx_in     = idx_ff;
      rdv_in     = rdv_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      ram_we     = 1'b0;
      ram_waddr  = wr_addr_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = probe_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_data.action;
               value_in  = widen(req_data.value);
               pos_in    = req_pos_idx[IDX_W-1:0];
               status_in = STAT_OK;
               idx_in    = '0;
               rdv_in    = '0;
               lo_in     = '0;
               hi_in     = count_ff;
               less_in   = 1'b0;
               pend_in   = 1'b0;
               unique case (req_data.action)
                  ACT_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                        state_in  = ST_FINISH;
                     end else if (count_ff == '0) begin
                        slot_in  = '0;
                        ptr_in   = '0;
                        state_in = ST_SHIFT;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  ACT_FIND: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_FINISH;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  ACT_READ: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_FINISH;
                     end else if (req_pos_wide >= count_wide) begin
                        status_in = STAT_RANGE;
                        state_in  = ST_FINISH;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = probe_idx;
               mid_in    = probe_idx;
               state_in  = ST_COMPARE;
            end else if (action_ff == ACT_INSERT) begin
               // The search ran out: the value goes at the last probe if it was
               // smaller than that entry, otherwise just after it.
               slot_in  = less_ff ? mid_ff : mid_ff + IDX_W'(1);
               ptr_in   = count_ff;
               state_in = ST_SHIFT;
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_FINISH;
            end
         end
         ST_COMPARE: begin
            if (cmp.equal) begin
               if (action_ff == ACT_INSERT) begin
                  slot_in  = mid_ff + IDX_W'(1);
                  ptr_in   = count_ff;
                  state_in = ST_SHIFT;
               end else begin
                  idx_in   = mid_ff;
                  state_in = ST_FINISH;
               end
            end else begin
               less_in = cmp.less;
               if (cmp.less) begin
                  hi_in = CNT_W'(mid_ff);
               end else begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_SHIFT: begin
            // Read entry ptr-1 while the entry read in the previous shift step lands one slot up.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (ptr_ff > CNT_W'(slot_ff)) begin
               ram_raddr  = ptr_m1[IDX_W-1:0];
               ptr_in     = ptr_m1;
               pend_in    = 1'b1;
               wr_addr_in = ptr_ff[IDX_W-1:0];
            end else begin
               pend_in  = 1'b0;
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            ram_wdata = value_ff;
            count_in  = count_ff + CNT_W'(1);
            idx_in    = slot_ff;
            if (slot_ff == '0) begin
               first_in = value_ff;
            end
            if (CNT_W'(slot_ff) == count_ff) begin
               last_in = value_ff;
            end
            state_in = ST_FINISH;
         end
         ST_FETCH: begin
            ram_raddr = pos_ff;
            state_in  = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            rdv_in   = ram_rdata;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.status      = status_ff;
      rsp_data_in.found_index = idx_wide[INDEX_W-1:0];
      rsp_data_in.read_value  = to_field(rdv_ff);
      rsp_data_in.entry_count = cnt_wide[COUNT_W-1:0];
      rsp_data_in.smallest    = (count_ff != '0) ? to_field(first_ff) : '0;
      rsp_data_in.largest     = (count_ff != '0) ? to_field(last_ff) : '0;
      rsp_valid_in            = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      less_ff    <= less_in;
      slot_ff    <= slot_in;
      ptr_ff     <= ptr_in;
      wr_addr_ff <= wr_addr_in;
      status_ff  <= status_in;
      idx_ff     <= idx_in;
      rdv_ff     <= rdv_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_shift_above_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (ptr_ff >= CNT_W'(slot_ff)))
      else $error("shift pointer moved below the insert slot");

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not add exactly one entry");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response beat raised outside the finish step");

endmodule

FILE: rtl/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the sorted array table. No dependencies.
module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sat_cmp.sv
// Shared signed compare unit used by every search probe.
// Depends on sat_pkg for the compare result struct.
module sat_cmp
   import sat_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic [VALUE_WIDTH-1:0] key,
   input  logic [VALUE_WIDTH-1:0] entry,
   output cmp_type                result
);

   always_comb begin
      result.less  = $signed(key) < $signed(entry);
      result.equal = key == entry;
   end

endmodule
